/* hdl/pfts_pkg.sv */
// Package for the phase-field thermal stencil step: types, constants, helpers.
// No dependencies.
`timescale 1ns / 1ps
package pfts_pkg;
    localparam int GRID_CELLS_DEF = 512;
    localparam int FRAC_BITS_DEF  = 20;
    localparam int VW             = 24;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MOBILITY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WELL       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KAPPA      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_MELT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MELT_TEMP  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THERM_DIFF = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LAT_HEAT   = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_OUT0,
        ST_OUT1
    } t_state;

    // Saturate a wide signed value to the 24-bit range.
    function automatic logic signed [VW-1:0] sat(input logic signed [63:0] x);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd8388607;
        lo = -64'sd8388608;
        if (x > hi) sat = hi[VW-1:0];
        else if (x < lo) sat = lo[VW-1:0];
        else sat = x[VW-1:0];
    endfunction
endpackage

/* hdl/phase_field_thermal_stencil_step.sv */
// Top level of the phase-field thermal stencil step: window, sequencer,
// shared multiplier and output register. Depends on pfts_pkg.
`timescale 1ns / 1ps
// One explicit Euler step of a 1D phase-field model with thermal coupling.
// Cells stream in grid order; each item after the second triggers one
// interior-cell update computed by a single shared 25x25 multiplier under a
// micro-program of 14 steps, and a second result is added when a boundary
// copy is due. The first two cells of a grid yield no result and are taken
// without leaving the idle state. The first and last cells get copies of
// their neighbour's new value. Results sit in an output register; the
// block takes no new item until all results of the current item are taken.
module phase_field_thermal_stencil_step #(
    parameter int GRID_CELLS = pfts_pkg::GRID_CELLS_DEF,
    parameter int FRAC_BITS  = pfts_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pfts_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pfts_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [pfts_pkg::VW-1:0]     i_phase_in,
    input  logic signed [pfts_pkg::VW-1:0]     i_temp_in,
    input  logic                               i_row_end,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [pfts_pkg::VW-1:0]     o_phase_out,
    output logic signed [pfts_pkg::VW-1:0]     o_temp_out,
    output logic                               o_last_out
);
    localparam int VW    = pfts_pkg::VW;
    localparam int AW    = 28;
    localparam int POS_W = $clog2(GRID_CELLS);
    localparam int NSTEP = 14;
    localparam int SW    = $clog2(NSTEP + 1);
    localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    // configuration
    logic [20:0]          r_dt;
    logic [22:0]          r_mob, r_well, r_kap, r_lm, r_kd, r_lh;
    logic signed [VW-1:0] r_tm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt   <= 21'd31457;
            r_mob  <= 23'd1048576;
            r_well <= 23'd1384120;
            r_kap  <= 23'd7149382;
            r_lm   <= 23'd1048576;
            r_tm   <= 24'sd1048576;
            r_kd   <= 23'd1048576;
            r_lh   <= 23'd1048576;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pfts_pkg::REG_TIME_STEP:  r_dt   <= i_cfg_data[20:0];
                pfts_pkg::REG_MOBILITY:   r_mob  <= i_cfg_data[22:0];
                pfts_pkg::REG_WELL:       r_well <= i_cfg_data[22:0];
                pfts_pkg::REG_KAPPA:      r_kap  <= i_cfg_data[22:0];
                pfts_pkg::REG_LAT_MELT:   r_lm   <= i_cfg_data[22:0];
                pfts_pkg::REG_MELT_TEMP:  r_tm   <= i_cfg_data;
                pfts_pkg::REG_THERM_DIFF: r_kd   <= i_cfg_data[22:0];
                pfts_pkg::REG_LAT_HEAT:   r_lh   <= i_cfg_data[22:0];
                default: ;
            endcase
        end
    end

    // window and control
    pfts_pkg::t_state     r_state, n_state;
    logic [SW-1:0]        r_step;
    logic [POS_W-1:0]     r_pos;
    logic                 r_last, r_two;
    logic signed [VW-1:0] r_cl, r_c, r_cr, r_tl, r_t, r_tr;
    // intermediates
    logic signed [VW-1:0] r_poly, r_mu, r_g, r_lapc, r_lapt, r_tmt;
    logic signed [VW-1:0] r_drv, r_cn, r_tn, r_x;
    // exact sum of the terms of drive and of the new temperature
    logic signed [AW-1:0] r_a;
    logic signed [VW-1:0] r_oc, r_ot;
    logic                 r_ol;

    wire accept = i_valid && o_ready;
    wire is_last = i_row_end || (r_pos == POS_W'(GRID_CELLS - 1));

    // shared multiplier operands picked by the step counter
    logic signed [VW:0]   m_a, m_b;
    logic signed [63:0]   m_p;
    logic signed [VW-1:0] m_r;

    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_step)
            SW'(0):  begin m_a = (VW+1)'(r_c); m_b = (VW+1)'(r_c); end
            SW'(1):  begin m_a = (VW+1)'(r_c); m_b = (VW+1)'(r_poly); end
            SW'(2):  begin
                m_a = (VW+1)'(r_c);
                m_b = (VW+1)'(pfts_pkg::sat(ONE - 64'(r_c)));
            end
            SW'(3):  begin m_a = (VW+1)'(r_tmt); m_b = (VW+1)'(r_g); end
            SW'(4):  begin m_a = {2'b0, r_lm}; m_b = (VW+1)'(r_x); end
            SW'(5):  begin m_a = {2'b0, r_well}; m_b = (VW+1)'(r_mu); end
            SW'(6):  begin m_a = {2'b0, r_kap}; m_b = (VW+1)'(r_lapc); end
            SW'(7):  begin m_a = {2'b0, r_mob}; m_b = (VW+1)'(r_drv); end
            SW'(8):  begin m_a = {4'b0, r_dt}; m_b = (VW+1)'(r_x); end
            SW'(9):  begin m_a = {2'b0, r_kd}; m_b = (VW+1)'(r_lapt); end
            SW'(10): begin m_a = {4'b0, r_dt}; m_b = (VW+1)'(r_x); end
            SW'(11): begin
                m_a = (VW+1)'(r_g);
                m_b = (VW+1)'(pfts_pkg::sat(64'(r_cn) - 64'(r_c)));
            end
            SW'(12): begin m_a = {2'b0, r_lh}; m_b = (VW+1)'(r_x); end
            default: ;
        endcase
        m_p = 64'(m_a) * 64'(m_b) + HALF;
        m_r = pfts_pkg::sat(m_p >>> FRAC_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pfts_pkg::ST_IDLE;
            r_step  <= '0;
            r_pos   <= '0;
            r_c     <= '0;
            r_cr    <= '0;
            r_t     <= '0;
            r_tr    <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                // shift window: old pair becomes left/center, new item is right
                r_cl   <= r_c;  r_c <= r_cr; r_cr <= i_phase_in;
                r_tl   <= r_t;  r_t <= r_tr; r_tr <= i_temp_in;
                r_last <= is_last;
                r_two  <= (r_pos == POS_W'(2));
                r_pos  <= is_last ? '0 : r_pos + POS_W'(1);
                r_step <= '0;
            end else if (r_state == pfts_pkg::ST_CALC) begin
                r_step <= r_step + SW'(1);
            end
        end
    end

    // datapath update per step
    always_ff @(posedge i_clk) begin
        if (r_state == pfts_pkg::ST_CALC) begin
            case (r_step)
                SW'(0): begin
                    r_poly <= pfts_pkg::sat(ONE - 3 * 64'(r_c) + 2 * 64'(m_r));
                    r_lapc <= pfts_pkg::sat(64'(r_cl) + 64'(r_cr) - 2 * 64'(r_c));
                    r_lapt <= pfts_pkg::sat(64'(r_tl) + 64'(r_tr) - 2 * 64'(r_t));
                    r_tmt  <= pfts_pkg::sat(64'(r_t) - 64'(r_tm));
                end
                SW'(1):  r_mu <= pfts_pkg::sat(2 * 64'(m_r));
                SW'(2):  r_g  <= m_r;
                SW'(3):  r_x  <= m_r;
                SW'(4):  r_a  <= AW'(-6 * 64'(m_r));
                SW'(5):  r_a  <= AW'(64'(r_a) - 64'(m_r));
                SW'(6):  r_drv <= pfts_pkg::sat(64'(r_a) + 2 * 64'(m_r));
                SW'(7):  r_x  <= m_r;
                SW'(8):  r_cn <= pfts_pkg::sat(64'(r_c) + 64'(m_r));
                SW'(9):  r_x  <= m_r;
                SW'(10): r_a  <= AW'(64'(r_t) + 64'(m_r));
                SW'(11): r_x  <= m_r;
                SW'(12): r_tn <= pfts_pkg::sat(64'(r_a) + 6 * 64'(m_r));
                default: ;
            endcase
        end
        if (r_state == pfts_pkg::ST_CALC && r_step == SW'(NSTEP - 1)) begin
            r_oc <= r_cn;
            r_ot <= r_tn;
            r_ol <= 1'b0;
        end else if (r_state == pfts_pkg::ST_OUT0 && i_ready) begin
            r_ol <= 1'b1 & (r_two ? r_last : 1'b1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pfts_pkg::ST_IDLE:
                if (accept && r_pos >= POS_W'(2)) n_state = pfts_pkg::ST_CALC;
            pfts_pkg::ST_CALC:
                if (r_step == SW'(NSTEP - 1)) n_state = pfts_pkg::ST_OUT0;
            pfts_pkg::ST_OUT0:
                if (i_ready) n_state = (r_two || (r_last && !r_ol)) ?
                                       pfts_pkg::ST_OUT1 : pfts_pkg::ST_IDLE;
            pfts_pkg::ST_OUT1:
                if (i_ready) n_state = pfts_pkg::ST_IDLE;
            default: n_state = pfts_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_ready = (r_state == pfts_pkg::ST_IDLE);
        o_valid = (r_state == pfts_pkg::ST_OUT0) || (r_state == pfts_pkg::ST_OUT1);
    end
    assign o_phase_out = r_oc;
    assign o_temp_out  = r_ot;
    assign o_last_out  = r_ol;

    // checks
    a_no_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_phase_out) && $stable(o_temp_out))
        else $error("result changed under stall");
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pfts_pkg::ST_CALC |-> r_step < SW'(NSTEP))
        else $error("step counter overrun");
endmodule
